>>> rtl/kmp_pkg.sv
// package: shared widths, sequencer states and pattern byte selection for the kmp matcher
package kmp_pkg;

  localparam int LEN_W     = 5;
  localparam int PAT_W     = 64;
  localparam int PAT_IDX_W = 4;
  localparam int BYTE_W    = 8;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SCAN,
    ST_MATCH
  } kmp_state_t;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_TEXT  = 1'b1
  } kmp_cmd_t;

  typedef struct packed {
    logic hit;
    logic fall;
  } step_flags_t;

  function automatic logic [BYTE_W-1:0] pat_byte(
    input logic [PAT_IDX_W-1:0] idx,
    input logic [PAT_W-1:0]     low,
    input logic [PAT_W-1:0]     high
  );
    logic [PAT_W-1:0] w;
    w = idx[PAT_IDX_W-1] ? high : low;
    return w[idx[PAT_IDX_W-2:0]*BYTE_W +: BYTE_W];
  endfunction

endpackage

>>> rtl/kmp_prefix_table.sv
// generic ram: one write port and one read port with registered read data
module kmp_prefix_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entries [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    rd_data <= entries[rd_addr];
  end

endmodule

>>> rtl/kmp_step.sv
// shared kmp step unit: pattern byte compare, advance, table fallback or hold at zero
module kmp_step #(
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic [CNT_W-1:0]            k,
  input  logic [kmp_pkg::BYTE_W-1:0]  sym,
  input  logic [kmp_pkg::PAT_W-1:0]   pat_low,
  input  logic [kmp_pkg::PAT_W-1:0]   pat_high,
  input  logic [IDX_W-1:0]            tab_rd,
  output kmp_pkg::step_flags_t        flags,
  output logic [CNT_W-1:0]            k_step
);
  import kmp_pkg::*;

  logic [BYTE_W-1:0] pbyte;

  assign pbyte      = pat_byte(PAT_IDX_W'(k), pat_low, pat_high);
  assign flags.hit  = (pbyte == sym);
  assign flags.fall = (k != '0) && (pbyte != sym);

  always_comb begin
    if (flags.fall) begin
      k_step = CNT_W'(tab_rd);
    end else if (flags.hit) begin
      k_step = k + CNT_W'(1);
    end else begin
      k_step = k;
    end
  end

endmodule

>>> rtl/kmp_stream_matcher.sv
// kmp stream matcher top level: configuration, sequencer, position counter and output register
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes pattern_length (0),
//   pattern bytes 0-7 (1) and pattern bytes 8-15 (2); always ready, write only when idle.
//   in channel (in_valid/in_stall, cmd, text_byte): cmd begin rebuilds the prefix table,
//   clears the match count and zeroes the text position; cmd text feeds one byte.
//   out channel (out_valid/out_stall, match_start) carries the start position of each
//   match, overlapping matches included.
//   A begin transfer writes all MAX_PATTERN table entries, one table entry per cycle except
//   while the build is taking a table fallback.
//   A text byte steps through the table fallbacks it needs, then advances, and goes on to
//   the match step when it completes a match; the shared compare unit does one step per cycle.
//   Text before the first begin is dropped.
//   A match passes from its last compare step through the match step into the output register.
//   The output register holds one result; while it is stalled and full, the next match
//   waits in the match step and the input stays stalled.
//   Reset clears the sequencer, match count, text position and output valid; the pattern length returns
//   to 1 and the pattern bytes to zero. The table is rebuilt by every begin.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmp_pkg::PAT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [kmp_pkg::BYTE_W-1:0]    text_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kmp_pkg::OUT_W-1:0]     match_start
);
  import kmp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  kmp_state_t state, state_next;

  logic [LEN_W-1:0]         pattern_length;
  logic [PAT_W-1:0]         pattern_low;
  logic [PAT_W-1:0]         pattern_high;
  logic [CNT_W-1:0]         k, k_next;
  logic [IDX_W-1:0]         j, j_next;
  logic [CNT_W-1:0]         matched_count, matched_count_next;
  logic [POSITION_BITS-1:0] text_position, text_position_next;
  logic [BYTE_W-1:0]        cur_byte, cur_byte_next;
  logic                     table_ready, table_ready_next;
  logic                     out_valid_next;
  logic [OUT_W-1:0]         match_start_next;

  logic [CNT_W-1:0]         len;
  logic [IDX_W-1:0]         len_m1;
  logic                     out_free;
  logic                     in_xfer;

  logic                     tab_we;
  logic [IDX_W-1:0]         tab_waddr;
  logic [IDX_W-1:0]         tab_wdata;
  logic [IDX_W-1:0]         tab_raddr;
  logic [IDX_W-1:0]         tab_rdata;

  logic [BYTE_W-1:0]        step_sym;
  step_flags_t              step_flags;
  logic [CNT_W-1:0]         step_k;
  logic [POSITION_BITS-1:0] start_pos;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (pattern_length == '0) begin
      len = CNT_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = CNT_W'(MAX_PATTERN);
    end else begin
      len = CNT_W'(pattern_length);
    end
  end

  assign len_m1    = IDX_W'(len - CNT_W'(1));
  assign step_sym  = (state == ST_BUILD) ? pat_byte(PAT_IDX_W'(j), pattern_low, pattern_high)
                                         : cur_byte;
  assign start_pos = text_position - POSITION_BITS'(len) + POSITION_BITS'(1);

  kmp_prefix_table #(
    .DEPTH (MAX_PATTERN),
    .AW    (IDX_W),
    .WIDTH (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_waddr),
    .wr_data (tab_wdata),
    .rd_addr (tab_raddr),
    .rd_data (tab_rdata)
  );

  kmp_step #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_step (
    .k        (k),
    .sym      (step_sym),
    .pat_low  (pattern_low),
    .pat_high (pattern_high),
    .tab_rd   (tab_rdata),
    .flags    (step_flags),
    .k_step   (step_k)
  );

  always_comb begin
    state_next         = state;
    k_next             = k;
    j_next             = j;
    matched_count_next = matched_count;
    text_position_next = text_position;
    cur_byte_next      = cur_byte;
    table_ready_next   = table_ready;
    out_valid_next     = out_valid && out_stall;
    match_start_next   = match_start;
    tab_we             = 1'b0;
    tab_waddr          = j;
    tab_wdata          = '0;

    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd == CMD_BEGIN) begin
            tab_we             = 1'b1;
            tab_waddr          = '0;
            tab_wdata          = '0;
            k_next             = '0;
            j_next             = IDX_W'(1);
            matched_count_next = '0;
            text_position_next = '0;
            if (MAX_PATTERN > 1) begin
              state_next = ST_BUILD;
            end else begin
              table_ready_next = 1'b1;
            end
          end else if (table_ready) begin
            cur_byte_next = text_byte;
            k_next        = (matched_count >= len) ? '0 : matched_count;
            state_next    = ST_SCAN;
          end
        end
      end

      ST_BUILD: begin
        if (CNT_W'(j) < len) begin
          if (step_flags.fall) begin
            k_next = step_k;
          end else begin
            k_next    = step_k;
            tab_we    = 1'b1;
            tab_wdata = IDX_W'(step_k);
          end
        end else begin
          tab_we    = 1'b1;
          tab_wdata = '0;
        end
        if (tab_we) begin
          if (j == IDX_W'(MAX_PATTERN - 1)) begin
            table_ready_next = 1'b1;
            state_next       = ST_IDLE;
          end else begin
            j_next = j + IDX_W'(1);
          end
        end
      end

      ST_SCAN: begin
        if (step_flags.fall) begin
          k_next = step_k;
        end else if (step_k >= len) begin
          state_next = ST_MATCH;
        end else begin
          matched_count_next = step_k;
          text_position_next = text_position + POSITION_BITS'(1);
          state_next         = ST_IDLE;
        end
      end

      ST_MATCH: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          match_start_next   = OUT_W'(start_pos);
          matched_count_next = CNT_W'(tab_rdata);
          text_position_next = text_position + POSITION_BITS'(1);
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // read address for the next cycle's table entry
    if (state_next == ST_MATCH) begin
      tab_raddr = len_m1;
    end else begin
      tab_raddr = IDX_W'(k_next - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pattern_length <= LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
      matched_count  <= '0;
      text_position  <= '0;
      table_ready    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state         <= state_next;
      matched_count <= matched_count_next;
      text_position <= text_position_next;
      table_ready   <= table_ready_next;
      out_valid     <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
          REG_PATTERN_LOW:    pattern_low    <= cfg_data;
          REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k           <= k_next;
    j           <= j_next;
    cur_byte    <= cur_byte_next;
    match_start <= match_start_next;
  end

endmodule
